// File: hw/rtl/lpg_pkg.sv
// Shared types and constants of the line pixel generator.
package lpg_pkg;

  localparam int unsigned COORD_BITS     = 12;
  localparam int unsigned ADDR_BITS      = 24;
  localparam int unsigned PITCH_BITS     = 13;
  localparam int unsigned COLOR_BITS     = 32;
  localparam int unsigned APB_ADDR_BITS  = 3;
  localparam int unsigned APB_DATA_BITS  = 32;

  localparam logic [PITCH_BITS-1:0] ROW_PITCH_RESET = PITCH_BITS'(640);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } lpg_op_e;

  // register index, taken from the word address
  typedef enum logic {
    REG_ROW_PITCH  = 1'b0,
    REG_DRAW_COLOR = 1'b1
  } lpg_reg_e;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef struct packed {
    lpg_op_e operation;
    coord_t  x_start;
    coord_t  y_start;
    coord_t  x_end;
    coord_t  y_end;
  } line_cmd_t;

  typedef struct packed {
    logic                  pixel_valid;
    coord_t                pixel_x;
    coord_t                pixel_y;
    addr_t                 pixel_address;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  line_last;
  } pixel_wr_t;

  typedef struct packed {
    logic [PITCH_BITS-1:0] row_pitch;
    logic [COLOR_BITS-1:0] draw_color;
  } lpg_cfg_t;

endpackage

// File: hw/rtl/lpg_cfg_regs.sv
// APB register file: row pitch and draw colour.
module lpg_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpg_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lpg_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [lpg_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  output lpg_pkg::lpg_cfg_t                 cfg_o
);
  import lpg_pkg::*;

  lpg_reg_e              reg_sel;
  logic                  wr_en;
  logic [PITCH_BITS-1:0] row_pitch_d, row_pitch_q;
  logic [COLOR_BITS-1:0] draw_color_d, draw_color_q;

  // byte offset bits are ignored, one register per word
  assign reg_sel = lpg_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    row_pitch_d  = row_pitch_q;
    draw_color_d = draw_color_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_ROW_PITCH:  row_pitch_d  = pwdata[PITCH_BITS-1:0];
        REG_DRAW_COLOR: draw_color_d = pwdata[COLOR_BITS-1:0];
        default:        row_pitch_d  = row_pitch_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pitch_q  <= ROW_PITCH_RESET;
      draw_color_q <= '0;
    end else begin
      row_pitch_q  <= row_pitch_d;
      draw_color_q <= draw_color_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROW_PITCH:  prdata = APB_DATA_BITS'(row_pitch_q);
      REG_DRAW_COLOR: prdata = APB_DATA_BITS'(draw_color_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.row_pitch  = row_pitch_q;
  assign cfg_o.draw_color = draw_color_q;

endmodule

// File: hw/rtl/lpg_step.sv
// Line state and Bresenham step; result is combinational.
module lpg_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  lpg_pkg::line_cmd_t cmd_i,
  input  lpg_pkg::lpg_cfg_t  cfg_i,
  output lpg_pkg::pixel_wr_t pix_o
);
  import lpg_pkg::*;

  // line state
  logic                active_q;
  coord_t              x_q, y_q;
  addr_t               addr_q;
  logic [COORD_BITS:0] err_q;
  coord_t              remain_q;
  logic                major_x_q;
  logic                x_move_q, x_neg_q, y_move_q, y_neg_q;
  coord_t              span_x_q, span_y_q;

  // start path
  coord_t                           span_x_s, span_y_s, remain_s;
  logic                             major_x_s;
  logic [PITCH_BITS+COORD_BITS-1:0] row_base;
  addr_t                            start_addr;

  // advance path
  coord_t              major_span, minor_span;
  logic [COORD_BITS:0] err_sum, err_next;
  logic                minor_step, do_x, do_y;
  coord_t              x_next, y_next;
  addr_t               pitch_ext, dx_term, dy_term, addr_next;

  assign span_x_s  = (cmd_i.x_end >= cmd_i.x_start) ? cmd_i.x_end - cmd_i.x_start
                                                    : cmd_i.x_start - cmd_i.x_end;
  assign span_y_s  = (cmd_i.y_end >= cmd_i.y_start) ? cmd_i.y_end - cmd_i.y_start
                                                    : cmd_i.y_start - cmd_i.y_end;
  assign major_x_s = span_x_s >= span_y_s;
  assign remain_s  = major_x_s ? span_x_s : span_y_s;
  assign row_base  = cfg_i.row_pitch * cmd_i.y_start;
  assign start_addr = ADDR_BITS'(row_base) + ADDR_BITS'(cmd_i.x_start);

  assign major_span = major_x_q ? span_x_q : span_y_q;
  assign minor_span = major_x_q ? span_y_q : span_x_q;
  // err_q stays below the major span, so the sum fits one extra bit
  assign err_sum    = err_q + {1'b0, minor_span};
  assign minor_step = err_sum >= {1'b0, major_span};
  assign err_next   = minor_step ? err_sum - {1'b0, major_span} : err_sum;

  assign do_x = x_move_q & (major_x_q | minor_step);
  assign do_y = y_move_q & (~major_x_q | minor_step);

  assign x_next = do_x ? (x_neg_q ? x_q - 1'b1 : x_q + 1'b1) : x_q;
  assign y_next = do_y ? (y_neg_q ? y_q - 1'b1 : y_q + 1'b1) : y_q;

  assign pitch_ext = ADDR_BITS'(cfg_i.row_pitch);
  assign dx_term   = do_x ? (x_neg_q ? '1 : ADDR_BITS'(1)) : '0;
  assign dy_term   = do_y ? (y_neg_q ? ADDR_BITS'(0) - pitch_ext : pitch_ext) : '0;
  assign addr_next = addr_q + dx_term + dy_term;

  always_comb begin
    pix_o = '0;
    unique case (cmd_i.operation)
      OP_START: begin
        pix_o.pixel_valid   = 1'b1;
        pix_o.pixel_x       = cmd_i.x_start;
        pix_o.pixel_y       = cmd_i.y_start;
        pix_o.pixel_address = start_addr;
        pix_o.pixel_color   = cfg_i.draw_color;
        pix_o.line_last     = remain_s == '0;
      end
      OP_ADVANCE: begin
        if (active_q) begin
          pix_o.pixel_valid   = 1'b1;
          pix_o.pixel_x       = x_next;
          pix_o.pixel_y       = y_next;
          pix_o.pixel_address = addr_next;
          pix_o.pixel_color   = cfg_i.draw_color;
          pix_o.line_last     = remain_q == COORD_BITS'(1);
        end
      end
      default: pix_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (fire_i) begin
      if (cmd_i.operation == OP_START) begin
        active_q <= remain_s != '0;
      end else if (active_q) begin
        active_q <= remain_q != COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      if (cmd_i.operation == OP_START) begin
        x_q       <= cmd_i.x_start;
        y_q       <= cmd_i.y_start;
        addr_q    <= start_addr;
        err_q     <= '0;
        remain_q  <= remain_s;
        major_x_q <= major_x_s;
        x_move_q  <= cmd_i.x_end != cmd_i.x_start;
        x_neg_q   <= cmd_i.x_end < cmd_i.x_start;
        y_move_q  <= cmd_i.y_end != cmd_i.y_start;
        y_neg_q   <= cmd_i.y_end < cmd_i.y_start;
        span_x_q  <= span_x_s;
        span_y_q  <= span_y_s;
      end else if (active_q) begin
        x_q      <= x_next;
        y_q      <= y_next;
        addr_q   <= addr_next;
        err_q    <= err_next;
        remain_q <= remain_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/line_pixel_generator_core.sv
// Top level of the line pixel generator: item registers, step unit, APB registers.
//
//   channel  direction  payload     handshake
//   in       into core  line_cmd_t  in_valid_i / in_stall_o
//   out      from core  pixel_wr_t  out_valid_o / out_stall_i
//   apb      into core  registers   psel / penable / pwrite, pready tied high
//
// One item per cycle unless stalled; each is registered at input, then at output.
// The rate is set by the step unit, which updates the line state in the same
// cycle (start address multiply, or error add and compare on an advance).
// Reset drops any active line; row pitch returns to 640, colour to 0.
// in_stall_o rises only when both item registers are full and out_stall_i is high.
module line_pixel_generator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lpg_pkg::line_cmd_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lpg_pkg::pixel_wr_t                out_item_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpg_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lpg_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [lpg_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import lpg_pkg::*;

  lpg_cfg_t  cfg;
  line_cmd_t in_item_q;
  pixel_wr_t out_item_q, step_pix;
  logic      in_valid_d, in_valid_q;
  logic      out_valid_d, out_valid_q;
  logic      advance, fire, in_accept;

  lpg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lpg_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cmd_i  (in_item_q),
    .cfg_i  (cfg),
    .pix_o  (step_pix)
  );

  // output register free or being emptied this cycle
  assign advance    = ~out_valid_q | ~out_stall_i;
  assign fire       = in_valid_q & advance;
  assign in_stall_o = in_valid_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= step_pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: hw/rtl/lpg_checker.sv
// Port-level checks of the line pixel generator, bound to the top level.
module lpg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input lpg_pkg::line_cmd_t in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lpg_pkg::pixel_wr_t out_item_o
);
  import lpg_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // input back-pressure only comes from a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // every taken item is followed by a valid result at the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("no result two cycles after an item");

  // an advance with no line gives an all-zero result
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.pixel_valid |->
      out_item_o.pixel_x == '0 && out_item_o.pixel_y == '0 &&
      out_item_o.pixel_address == '0 && out_item_o.pixel_color == '0 &&
      !out_item_o.line_last)
    else $error("empty result carries data");

endmodule

bind line_pixel_generator_core lpg_checker u_lpg_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for line_pixel_generator_core: line stepping, addresses, registers.
`timescale 1ns / 100ps

module testbench;
  import lpg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT  = 10;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  line_cmd_t                in_item_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  pixel_wr_t                out_item_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  line_pixel_generator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  // expected pixel writes, oldest first
  pixel_wr_t expected_pixels[$];

  // shadow of the registers and of the line state
  logic [PITCH_BITS-1:0] pitch_cfg;
  logic [COLOR_BITS-1:0] color_cfg;
  logic                  line_on;
  coord_t                pen_x;
  coord_t                pen_y;
  addr_t                 pen_addr;
  logic [12:0]           err_acc;
  logic [12:0]           steps_left;
  logic                  x_major;
  int                    dir_x;
  int                    dir_y;
  coord_t                run_x;
  coord_t                run_y;

  int idle_pct;
  int stall_pct;
  int fault_count;
  int cycle_count;
  int lines_started;
  int items_sent;
  int pixels_written;
  int empty_results;
  int reg_accesses;
  pixel_wr_t want_px;
  pixel_wr_t got_px;

  function automatic void move_x();
    if (dir_x > 0) begin
      pen_x    = pen_x + 1'b1;
      pen_addr = pen_addr + 1'b1;
    end else if (dir_x < 0) begin
      pen_x    = pen_x - 1'b1;
      pen_addr = pen_addr - 1'b1;
    end
  endfunction

  function automatic void move_y();
    if (dir_y > 0) begin
      pen_y    = pen_y + 1'b1;
      pen_addr = pen_addr + addr_t'(pitch_cfg);
    end else if (dir_y < 0) begin
      pen_y    = pen_y - 1'b1;
      pen_addr = pen_addr - addr_t'(pitch_cfg);
    end
  endfunction

  // Bresenham step: updates the shadow line state and gives the pixel write
  function automatic pixel_wr_t rasterize(input line_cmd_t cmd);
    pixel_wr_t   px;
    logic [31:0] base;
    px = '0;
    if (cmd.operation == OP_START) begin
      run_x = (cmd.x_end >= cmd.x_start) ? cmd.x_end - cmd.x_start : cmd.x_start - cmd.x_end;
      run_y = (cmd.y_end >= cmd.y_start) ? cmd.y_end - cmd.y_start : cmd.y_start - cmd.y_end;
      dir_x = (cmd.x_end > cmd.x_start) ? 1 : ((cmd.x_end < cmd.x_start) ? -1 : 0);
      dir_y = (cmd.y_end > cmd.y_start) ? 1 : ((cmd.y_end < cmd.y_start) ? -1 : 0);
      x_major    = run_x >= run_y;
      steps_left = x_major ? {1'b0, run_x} : {1'b0, run_y};
      err_acc    = '0;
      pen_x      = cmd.x_start;
      pen_y      = cmd.y_start;
      base       = 32'(pitch_cfg) * 32'(cmd.y_start) + 32'(cmd.x_start);
      pen_addr   = base[ADDR_BITS-1:0];
      line_on    = steps_left != 0;
    end else if (!line_on) begin
      return px;
    end else begin
      if (x_major) begin
        err_acc = err_acc + run_y;
        if (err_acc >= {1'b0, run_x}) begin
          err_acc = err_acc - run_x;
          move_y();
        end
        move_x();
      end else begin
        err_acc = err_acc + run_x;
        if (err_acc >= {1'b0, run_y}) begin
          err_acc = err_acc - run_y;
          move_x();
        end
        move_y();
      end
      steps_left = steps_left - 1'b1;
      line_on    = steps_left != 0;
    end
    px.pixel_valid   = 1'b1;
    px.pixel_x       = pen_x;
    px.pixel_y       = pen_y;
    px.pixel_address = pen_addr;
    px.pixel_color   = color_cfg;
    px.line_last     = steps_left == 0;
    return px;
  endfunction

  function automatic line_cmd_t start_cmd(input coord_t xs, input coord_t ys,
                                          input coord_t xe, input coord_t ye);
    line_cmd_t c;
    c.operation = OP_START;
    c.x_start   = xs;
    c.y_start   = ys;
    c.x_end     = xe;
    c.y_end     = ye;
    return c;
  endfunction

  // all point fields are don't-care on an advance, so fill them with noise
  function automatic line_cmd_t advance_cmd();
    line_cmd_t c;
    c.operation = OP_ADVANCE;
    c.x_start   = coord_t'($urandom);
    c.y_start   = coord_t'($urandom);
    c.x_end     = coord_t'($urandom);
    c.y_end     = coord_t'($urandom);
    return c;
  endfunction

  function automatic coord_t nudge(input coord_t origin, input int reach);
    int v;
    v = int'(origin) + int'($urandom_range(2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return coord_t'(v);
  endfunction

  task automatic send_cmd(input line_cmd_t cmd);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = cmd;
    do @(posedge clk_i); while (in_stall_o);
    expected_pixels.push_back(rasterize(cmd));
    items_sent++;
    if (cmd.operation == OP_START) lines_started++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input lpg_reg_e idx, input logic [APB_DATA_BITS-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ROW_PITCH:  pitch_cfg = value[PITCH_BITS-1:0];
      REG_DRAW_COLOR: color_cfg = value;
      default: ;
    endcase
    reg_accesses++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic reg_read(input lpg_reg_e idx);
    logic [APB_DATA_BITS-1:0] exp_val;
    exp_val = (idx == REG_ROW_PITCH) ? APB_DATA_BITS'(pitch_cfg) : color_cfg;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== exp_val) begin
      fault_count++;
      if (fault_count <= SHOW_LIMIT)
        $display("register %s read back %h, expected %h", idx.name(), prdata, exp_val);
    end
    reg_accesses++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(input logic [PITCH_BITS-1:0] pitch,
                            input logic [COLOR_BITS-1:0] color);
    wait_drained();
    reg_write(REG_ROW_PITCH, APB_DATA_BITS'(pitch));
    reg_write(REG_DRAW_COLOR, color);
    reg_read(REG_ROW_PITCH);
    reg_read(REG_DRAW_COLOR);
  endtask

  task automatic test_reset_values();
    reg_read(REG_ROW_PITCH);
    reg_read(REG_DRAW_COLOR);
  endtask

  task automatic test_directed_lines();
    idle_pct  = 0;
    stall_pct = 0;
    // advance with nothing active, then a single-point line at the far corner
    send_cmd(advance_cmd());
    send_cmd(start_cmd(12'd4095, 12'd4095, 12'd4095, 12'd4095));
    send_cmd(advance_cmd());
    // equal spans: x is major; one advance past the end
    send_cmd(start_cmd(12'd0, 12'd0, 12'd3, 12'd3));
    repeat (4) send_cmd(advance_cmd());
    // steep, x falling; then restarted mid-line
    send_cmd(start_cmd(12'd4095, 12'd0, 12'd4093, 12'd4095));
    repeat (2) send_cmd(advance_cmd());
    send_cmd(start_cmd(12'd0, 12'd4095, 12'd4095, 12'd4094));
    repeat (2) send_cmd(advance_cmd());
    // colour changed while the line is still active
    wait_drained();
    reg_write(REG_DRAW_COLOR, 32'hFFFF_FFFF);
    repeat (2) send_cmd(advance_cmd());
    // vertical upwards and horizontal leftwards
    send_cmd(start_cmd(12'd10, 12'd20, 12'd10, 12'd17));
    repeat (3) send_cmd(advance_cmd());
    send_cmd(start_cmd(12'd4095, 12'd5, 12'd4092, 12'd5));
    repeat (3) send_cmd(advance_cmd());
  endtask

  task automatic test_random_traffic(input int sender_idle, input int sink_stall,
                                     input logic [PITCH_BITS-1:0] pitch,
                                     input logic [COLOR_BITS-1:0] color,
                                     input int n_items, input bit drain_midway);
    line_cmd_t head;
    int        sent;
    int        reach;
    int        dx;
    int        dy;
    int        span;
    int        steps;
    bit        drained;
    set_config(pitch, color);
    idle_pct  = sender_idle;
    stall_pct = sink_stall;
    sent      = 0;
    drained   = 1'b0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        send_cmd(advance_cmd());
        sent++;
      end else begin
        reach = ($urandom_range(3) == 0) ? 48 : 8;
        head  = start_cmd(coord_t'($urandom), coord_t'($urandom), '0, '0);
        if ($urandom_range(9) == 0) begin
          head.x_end = coord_t'($urandom);
          head.y_end = coord_t'($urandom);
        end else begin
          head.x_end = nudge(head.x_start, reach);
          head.y_end = nudge(head.y_start, reach);
        end
        dx = int'(head.x_end) - int'(head.x_start);
        dy = int'(head.y_end) - int'(head.y_start);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        span = (dx >= dy) ? dx : dy;
        case ($urandom_range(9))
          0, 1:    steps = $urandom_range(span);          // cut short by a restart
          2:       steps = span + $urandom_range(1, 3);   // runs off the end
          default: steps = span;
        endcase
        if (steps > 64) steps = $urandom_range(24);
        send_cmd(head);
        repeat (steps) send_cmd(advance_cmd());
        sent += steps + 1;
      end
      if (drain_midway && !drained && sent >= n_items / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_px = out_item_o;
      if (expected_pixels.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOW_LIMIT)
          $display("unexpected pixel write: x=%0d y=%0d addr=%h", got_px.pixel_x,
                   got_px.pixel_y, got_px.pixel_address);
      end else begin
        want_px = expected_pixels.pop_front();
        if (got_px.pixel_valid !== want_px.pixel_valid || got_px.pixel_x !== want_px.pixel_x
            || got_px.pixel_y !== want_px.pixel_y
            || got_px.pixel_address !== want_px.pixel_address
            || got_px.pixel_color !== want_px.pixel_color
            || got_px.line_last !== want_px.line_last) begin
          fault_count++;
          if (fault_count <= SHOW_LIMIT)
            $display("pixel mismatch: exp v=%0b x=%0d y=%0d a=%h c=%h l=%0b / got v=%0b x=%0d y=%0d a=%h c=%h l=%0b",
                     want_px.pixel_valid, want_px.pixel_x, want_px.pixel_y,
                     want_px.pixel_address, want_px.pixel_color, want_px.line_last,
                     got_px.pixel_valid, got_px.pixel_x, got_px.pixel_y,
                     got_px.pixel_address, got_px.pixel_color, got_px.line_last);
        end
        if (want_px.pixel_valid) pixels_written++;
        else empty_results++;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    fault_count = 0;
    cycle_count = 0;
    lines_started  = 0;
    items_sent     = 0;
    pixels_written = 0;
    empty_results  = 0;
    reg_accesses   = 0;
    pitch_cfg  = ROW_PITCH_RESET;
    color_cfg  = '0;
    line_on    = 1'b0;
    pen_x      = '0;
    pen_y      = '0;
    pen_addr   = '0;
    err_acc    = '0;
    steps_left = '0;
    x_major    = 1'b0;
    dir_x      = 0;
    dir_y      = 0;
    run_x      = '0;
    run_y      = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_directed_lines();
    test_random_traffic(0, 0, 13'd1, 32'hFFFF_FFFF, 150, 1'b0);
    test_random_traffic(87, 0, 13'd4096, $urandom, 150, 1'b1);
    test_random_traffic(0, 87, 13'd0, 32'h0000_0000, 150, 1'b0);
    test_random_traffic(18, 18, 13'd8191, $urandom, 150, 1'b0);
    wait_drained();

    $display("Sent %0d items (%0d line starts); checked %0d pixel writes and %0d idle advances.",
             items_sent, lines_started, pixels_written, empty_results);
    $display("Row pitch 640, 1, 4096, 0 and 8191 exercised over %0d register accesses.",
             reg_accesses);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_cfg_regs.sv
hw/rtl/lpg_step.sv
hw/rtl/line_pixel_generator_core.sv
hw/rtl/lpg_checker.sv
tb/sv/testbench.sv
